FILE: hdl/bpfa_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bpfa_pkg
// Shared types and constants of the block pool allocator.
// ----------------------------------------------------------------------------
package bpfa_pkg;
    localparam int NUM_BLOCKS   = 16;
    localparam int NUM_PROGRAMS = 16;
    localparam int BLK_W   = $clog2(NUM_BLOCKS);
    localparam int PRG_W   = $clog2(NUM_PROGRAMS);
    localparam int HELD_DEPTH = NUM_BLOCKS * NUM_PROGRAMS;
    localparam int HADDR_W = $clog2(HELD_DEPTH);
    localparam int CNT_W   = $clog2(NUM_BLOCKS + 1);

    localparam logic [1:0] CMD_SETCAP  = 2'd0;
    localparam logic [1:0] CMD_ALLOC   = 2'd1;
    localparam logic [1:0] CMD_RELEASE = 2'd2;

    localparam logic [2:0] ST_FIT    = 3'd0;
    localparam logic [2:0] ST_FORCED = 3'd1;
    localparam logic [2:0] ST_NOMEM  = 3'd2;
    localparam logic [2:0] ST_ABSENT = 3'd3;
    localparam logic [2:0] ST_CAPSET = 3'd4;

    typedef enum logic [2:0] {
        OP_IDLE,
        OP_SCAN,
        OP_FIT,
        OP_FORCE,
        OP_REL,
        OP_CLEAR
    } op_t;

    typedef struct packed {
        op_t              op;
        logic [BLK_W-1:0] idx;
        logic             first;
    } dp_cmd_t;

    typedef struct packed {
        logic             found;
        logic             avail_ok;
        logic [BLK_W-1:0] pick;
        logic [BLK_W-1:0] first_used;
    } dp_stat_t;
endpackage
`default_nettype wire

FILE: hdl/bpfa_ram.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bpfa_ram
// Generic simple dual-port RAM with one write port and a registered read port.
// ----------------------------------------------------------------------------
module bpfa_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 256
) (
    input  wire logic                     aclk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    input  wire logic [WIDTH-1:0]         wdata,
    output logic      [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule
`default_nettype wire

FILE: hdl/bpfa_datapath.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bpfa_datapath
// Block free counts, pool total, held-bytes memory and scan arithmetic.
// ----------------------------------------------------------------------------
module bpfa_datapath import bpfa_pkg::*; (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire dp_cmd_t          cmd,
    input  wire logic             setcap_en,
    input  wire logic [3:0]       setcap_idx,
    input  wire logic [15:0]      byte_count,
    input  wire logic [PRG_W-1:0] tag,
    input  wire logic             best_fit,
    output dp_stat_t              stat,
    output logic [19:0]           total_free
);
    logic [15:0] free_reg [NUM_BLOCKS];
    logic [19:0] total_reg;
    logic [19:0] avail_reg;
    logic        found_reg, used_reg;
    logic [BLK_W-1:0] pick_reg, first_reg;
    logic [15:0] left_reg, need_reg;

    logic              h_we;
    logic [HADDR_W-1:0] h_waddr, h_raddr;
    logic [15:0]       h_wdata, h_rdata;

    bpfa_ram #(.WIDTH(16), .DEPTH(HELD_DEPTH)) u_held (
        .aclk(aclk), .we(h_we), .waddr(h_waddr), .raddr(h_raddr),
        .wdata(h_wdata), .rdata(h_rdata)
    );

    logic [15:0] f_cur, take, room, add, left;
    logic [16:0] hsum;
    logic        fits;

    always_comb begin
        f_cur = free_reg[cmd.idx];
        fits  = f_cur >= byte_count;
        left  = f_cur - byte_count;
        take  = (f_cur < need_reg) ? f_cur : need_reg;
        room  = 16'hFFFF - f_cur;
        add   = (h_rdata > room) ? room : h_rdata;
        hsum  = {1'b0, h_rdata} + {1'b0, (cmd.op == OP_FIT) ? byte_count : take};
        h_waddr = HADDR_W'({tag, cmd.idx});
        h_raddr = (cmd.op == OP_FIT) ? HADDR_W'({tag, cmd.idx})
                                     : HADDR_W'({tag, cmd.idx + BLK_W'(1)});
        h_we    = 1'b0;
        h_wdata = hsum[16] ? 16'hFFFF : hsum[15:0];
        case (cmd.op)
            OP_FIT:   h_we = !cmd.first;
            OP_FORCE: h_we = !cmd.first && need_reg != 16'd0 && f_cur != 16'd0;
            OP_REL: begin
                h_we    = !cmd.first;
                h_wdata = 16'd0;
            end
            OP_CLEAR: begin
                h_we    = 1'b1;
                h_wdata = 16'd0;
                h_waddr = HADDR_W'({tag, cmd.idx});
            end
            default: h_we = 1'b0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < NUM_BLOCKS; i++) free_reg[i] <= '0;
            total_reg <= '0;
        end else begin
            if (setcap_en && {1'b0, setcap_idx} < 5'(NUM_BLOCKS)) begin
                free_reg[BLK_W'(setcap_idx)] <= byte_count;
                total_reg <= total_reg - 20'(free_reg[BLK_W'(setcap_idx)])
                             + 20'(byte_count);
            end
            case (cmd.op)
                OP_SCAN: begin
                    if (cmd.first) begin
                        avail_reg <= '0;
                        found_reg <= 1'b0;
                        pick_reg  <= '0;
                        left_reg  <= '0;
                    end else begin
                        avail_reg <= avail_reg + 20'(f_cur);
                        if (fits && (!found_reg || (best_fit && left < left_reg))) begin
                            found_reg <= 1'b1;
                            pick_reg  <= cmd.idx;
                            left_reg  <= left;
                        end
                    end
                end
                OP_FIT: begin
                    if (cmd.first) begin
                        free_reg[cmd.idx] <= f_cur - byte_count;
                        total_reg <= total_reg - 20'(byte_count);
                    end
                end
                OP_FORCE: begin
                    if (cmd.first) begin
                        need_reg  <= byte_count;
                        used_reg  <= 1'b0;
                        first_reg <= '0;
                    end else if (need_reg != 16'd0 && f_cur != 16'd0) begin
                        free_reg[cmd.idx] <= f_cur - take;
                        total_reg <= total_reg - 20'(take);
                        need_reg  <= need_reg - take;
                        if (!used_reg) begin
                            used_reg  <= 1'b1;
                            first_reg <= cmd.idx;
                        end
                    end
                end
                OP_REL: begin
                    if (!cmd.first) begin
                        free_reg[cmd.idx] <= f_cur + add;
                        total_reg <= total_reg + 20'(add);
                    end
                end
                default: ;
            endcase
        end
    end

    assign stat.found      = found_reg;
    assign stat.avail_ok   = avail_reg >= 20'(byte_count);
    assign stat.pick       = pick_reg;
    assign stat.first_used = first_reg;
    assign total_free      = total_reg;
endmodule
`default_nettype wire

FILE: hdl/bpfa_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bpfa_ctrl
// Sequencer: clearing pass, command decode, block walks and result handoff.
// ----------------------------------------------------------------------------
module bpfa_ctrl import bpfa_pkg::*; (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             s_valid,
    output logic                  s_ready,
    input  wire logic [1:0]       s_cmd,
    input  wire logic [PRG_W-1:0] tag,
    input  wire logic             tag_ok,
    input  wire logic             force_req,
    input  wire logic [4:0]       blocks_in_use,
    output logic                  m_valid,
    input  wire logic             m_ready,
    output logic [2:0]            m_status,
    output logic [3:0]            m_granted_block,
    output dp_cmd_t               cmd,
    output logic [PRG_W-1:0]      clr_tag,
    output logic                  setcap_en,
    output logic                  busy,
    input  wire dp_stat_t         stat
);
    typedef enum logic [3:0] {
        S_CLEAR, S_IDLE, S_SCAN, S_DECIDE, S_FIT, S_FORCE, S_REL, S_DONE
    } state_t;

    state_t state_reg;
    logic [PRG_W-1:0] clr_tag_reg;
    logic [CNT_W:0]   cnt_reg;
    logic [CNT_W-1:0] n_act;
    logic             present_reg [NUM_PROGRAMS];
    logic             last_clr;
    logic             ocnt_full;

    assign n_act = (blocks_in_use > 5'(NUM_BLOCKS)) ? CNT_W'(NUM_BLOCKS)
                                                   : CNT_W'(blocks_in_use);
    assign s_ready   = state_reg == S_IDLE && !m_valid;
    assign busy      = state_reg != S_IDLE || m_valid;
    assign setcap_en = s_valid && s_ready && s_cmd == CMD_SETCAP;
    assign last_clr  = clr_tag_reg == PRG_W'(NUM_PROGRAMS - 1);
    assign ocnt_full = 1'b0;
    assign clr_tag   = clr_tag_reg;

    always_comb begin
        cmd.op    = OP_IDLE;
        cmd.idx   = BLK_W'(cnt_reg[CNT_W-1:0] - CNT_W'(1));
        cmd.first = cnt_reg == '0;
        case (state_reg)
            S_CLEAR: begin
                cmd.op    = OP_CLEAR;
                cmd.idx   = BLK_W'(cnt_reg);
                cmd.first = 1'b0;
            end
            S_SCAN:  cmd.op = OP_SCAN;
            S_FIT: begin
                cmd.op    = OP_FIT;
                cmd.idx   = stat.pick;
                cmd.first = cnt_reg == '0;
            end
            S_FORCE: cmd.op = OP_FORCE;
            S_REL:   cmd.op = OP_REL;
            default: cmd.op = OP_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_CLEAR;
            cnt_reg     <= '0;
            clr_tag_reg <= '0;
            m_valid     <= 1'b0;
            m_status    <= ST_FIT;
            m_granted_block <= '0;
            for (int i = 0; i < NUM_PROGRAMS; i++) present_reg[i] <= 1'b0;
        end else begin
            if (m_valid && m_ready) m_valid <= 1'b0;
            case (state_reg)
                S_CLEAR: begin
                    if (cnt_reg == (CNT_W+1)'(NUM_BLOCKS - 1)) begin
                        cnt_reg     <= '0;
                        clr_tag_reg <= clr_tag_reg + PRG_W'(1);
                        if (last_clr || ocnt_full) state_reg <= S_IDLE;
                    end else begin
                        cnt_reg <= cnt_reg + (CNT_W+1)'(1);
                    end
                end
                S_IDLE: begin
                    cnt_reg <= '0;
                    if (s_valid && s_ready) begin
                        m_granted_block <= '0;
                        case (s_cmd)
                            CMD_SETCAP: begin
                                m_status <= ST_CAPSET;
                                state_reg <= S_DONE;
                            end
                            CMD_RELEASE: begin
                                if (!tag_ok || !present_reg[tag]) begin
                                    m_status  <= ST_ABSENT;
                                    state_reg <= S_DONE;
                                end else begin
                                    m_status  <= ST_FIT;
                                    present_reg[tag] <= 1'b0;
                                    state_reg <= S_REL;
                                end
                            end
                            CMD_ALLOC: begin
                                if (!tag_ok) begin
                                    m_status  <= ST_NOMEM;
                                    state_reg <= S_DONE;
                                end else begin
                                    state_reg <= S_SCAN;
                                end
                            end
                            default: begin
                                m_status  <= ST_ABSENT;
                                state_reg <= S_DONE;
                            end
                        endcase
                    end
                end
                S_SCAN, S_FORCE: begin
                    if (cnt_reg == (CNT_W+1)'(n_act)) begin
                        cnt_reg <= '0;
                        if (state_reg == S_SCAN) begin
                            state_reg <= S_DECIDE;
                        end else begin
                            m_status  <= ST_FORCED;
                            m_granted_block <= (cnt_reg == '0) ? 4'd0
                                                               : 4'(stat.first_used);
                            present_reg[tag] <= 1'b1;
                            state_reg <= S_DONE;
                        end
                    end else begin
                        cnt_reg <= cnt_reg + (CNT_W+1)'(1);
                    end
                end
                S_DECIDE: begin
                    cnt_reg <= '0;
                    if (stat.found) begin
                        state_reg <= S_FIT;
                    end else if (force_req && stat.avail_ok) begin
                        state_reg <= S_FORCE;
                    end else begin
                        m_status  <= ST_NOMEM;
                        state_reg <= S_DONE;
                    end
                end
                S_FIT: begin
                    if (cnt_reg == (CNT_W+1)'(2)) begin
                        m_status  <= ST_FIT;
                        m_granted_block <= 4'(stat.pick);
                        present_reg[tag] <= 1'b1;
                        state_reg <= S_DONE;
                    end else begin
                        cnt_reg <= cnt_reg + (CNT_W+1)'(1);
                    end
                end
                S_REL: begin
                    if (cnt_reg == (CNT_W+1)'(NUM_BLOCKS)) begin
                        state_reg <= S_DONE;
                    end else begin
                        cnt_reg <= cnt_reg + (CNT_W+1)'(1);
                    end
                end
                S_DONE: begin
                    m_valid   <= 1'b1;
                    state_reg <= S_IDLE;
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end
endmodule
`default_nettype wire

FILE: hdl/block_pool_fit_allocator.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// block_pool_fit_allocator
// Block pool allocator with first-fit / best-fit selection and forced spread.
// One item at a time, set by the walks over the blocks: a new command is
// taken only when idle with no result pending. After reset a clearing pass
// zeroes the held bytes of every program and block; no transfer is accepted
// meanwhile. Configuration writes are always taken.
// ----------------------------------------------------------------------------
module block_pool_fit_allocator import bpfa_pkg::*; (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [4:0]  cfg_data,
    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire logic [1:0]  s_cmd,
    input  wire logic [3:0]  s_block_index,
    input  wire logic [15:0] s_byte_count,
    input  wire logic [3:0]  s_program_tag,
    input  wire logic        s_best_fit,
    input  wire logic        s_force_req,
    output logic             m_valid,
    input  wire logic        m_ready,
    output logic [2:0]       m_status,
    output logic [3:0]       m_granted_block,
    output logic [19:0]      m_total_free
);
    logic [4:0]       blocks_in_use_reg;
    logic [15:0]      bytes_reg;
    logic [PRG_W-1:0] tag_reg;
    logic [PRG_W-1:0] clr_tag;
    logic             best_reg, force_reg;
    logic             tag_ok;
    logic             busy, setcap_en;
    logic [19:0]      total;
    dp_cmd_t          cmd;
    dp_stat_t         stat;

    assign cfg_ready = 1'b1;
    assign tag_ok = {1'b0, s_program_tag} < 5'(NUM_PROGRAMS);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            blocks_in_use_reg <= '0;
        end else if (cfg_valid && cfg_ready) begin
            blocks_in_use_reg <= cfg_data;
        end
        if (s_valid && s_ready) begin
            bytes_reg <= s_byte_count;
            tag_reg   <= PRG_W'(s_program_tag);
            best_reg  <= s_best_fit;
            force_reg <= s_force_req;
        end
    end

    bpfa_ctrl u_ctrl (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_cmd(s_cmd),
        .tag(s_ready ? PRG_W'(s_program_tag) : tag_reg), .tag_ok(tag_ok),
        .force_req(force_reg), .blocks_in_use(blocks_in_use_reg),
        .m_valid(m_valid), .m_ready(m_ready), .m_status(m_status),
        .m_granted_block(m_granted_block),
        .cmd(cmd), .clr_tag(clr_tag), .setcap_en(setcap_en), .busy(busy),
        .stat(stat)
    );

    bpfa_datapath u_dp (
        .aclk(aclk), .aresetn(aresetn), .cmd(cmd),
        .setcap_en(setcap_en && !busy), .setcap_idx(s_block_index),
        .byte_count(setcap_en ? s_byte_count : bytes_reg),
        .tag(cmd.op == OP_CLEAR ? clr_tag : tag_reg),
        .best_fit(best_reg), .stat(stat), .total_free(total)
    );

    assign m_total_free = total;
endmodule
`default_nettype wire
